// ----- rtl/i2cmrs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmrs_pkg
// Types, codes and helper functions of the I2C master register sequencer.
// ----------------------------------------------------------------------------
package i2cmrs_pkg;

  localparam int DEV_REGS  = 4;
  localparam int DEV_IDX_W = 2;
  localparam int DEV_ADR_W = 7;

  localparam logic [7:0] ST_CODE_BITS    = 8'hF8;
  localparam logic [7:0] ST_START        = 8'h08;
  localparam logic [7:0] ST_REP_START    = 8'h10;
  localparam logic [7:0] ST_MT_SLA_ACK   = 8'h18;
  localparam logic [7:0] ST_MT_DATA_ACK  = 8'h28;
  localparam logic [7:0] ST_MR_SLA_ACK   = 8'h40;
  localparam logic [7:0] ST_MR_DATA_ACK  = 8'h50;
  localparam logic [7:0] ST_MR_DATA_NACK = 8'h58;

  typedef enum logic [1:0] {
    MODE_ENQ   = 2'd0,
    MODE_EVENT = 2'd1,
    MODE_POLL  = 2'd2
  } mode_t;

  typedef enum logic [3:0] {
    STEP_W_START = 4'd0,
    STEP_W_ADDR  = 4'd1,
    STEP_W_REG   = 4'd2,
    STEP_W_VALUE = 4'd3,
    STEP_R_START = 4'd4,
    STEP_R_ADDR  = 4'd5,
    STEP_R_VALUE = 4'd6,
    STEP_R_DONE  = 4'd7,
    STEP_IDLE    = 4'd8
  } step_t;

  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_SEND  = 3'd2;
  localparam logic [2:0] CMD_STOP  = 3'd3;
  localparam logic [2:0] CMD_RECV  = 3'd4;

  localparam logic [2:0] ERR_OK    = 3'd0;
  localparam logic [2:0] ERR_START = 3'd1;
  localparam logic [2:0] ERR_ADDR  = 3'd2;
  localparam logic [2:0] ERR_REG   = 3'd3;
  localparam logic [2:0] ERR_VALUE = 3'd4;
  localparam logic [2:0] ERR_STOP  = 3'd5;

  typedef struct packed {
    logic [1:0] mode;
    logic       req_is_read;
    logic [1:0] req_device;
    logic [7:0] req_register;
    logic [7:0] req_value;
    logic [7:0] bus_status;
    logic [7:0] bus_data;
  } in_t;

  typedef struct packed {
    logic       accepted;
    logic [2:0] bus_cmd;
    logic [7:0] bus_byte;
    logic       done_res;
    logic [1:0] done_device;
    logic       done_was_read;
    logic [2:0] done_error;
    logic [7:0] read_data;
  } out_t;

  // one queued request
  typedef struct packed {
    logic       is_read;
    logic [1:0] device;
    logic [7:0] reg_addr;
    logic [7:0] value;
  } entry_t;

  function automatic logic status_has(input logic [7:0] st, input logic [7:0] code);
    status_has = ((st & ST_CODE_BITS & code) == code);
  endfunction

  // status code each step waits for
  function automatic logic [7:0] expect_code(input step_t st);
    logic [7:0] c;
    c = ST_START;
    unique case (st)
      STEP_W_START: c = ST_START;
      STEP_W_ADDR:  c = ST_MT_SLA_ACK;
      STEP_W_REG:   c = ST_MT_DATA_ACK;
      STEP_W_VALUE: c = ST_MT_DATA_ACK;
      STEP_R_START: c = ST_REP_START;
      STEP_R_ADDR:  c = ST_MR_SLA_ACK;
      STEP_R_VALUE: c = ST_MR_DATA_ACK;
      STEP_R_DONE:  c = ST_MR_DATA_NACK;
      default:      c = ST_START;
    endcase
    expect_code = c;
  endfunction

  function automatic logic [2:0] err_of(input step_t st);
    logic [2:0] e;
    e = ERR_OK;
    unique case (st)
      STEP_W_START, STEP_R_START: e = ERR_START;
      STEP_W_ADDR,  STEP_R_ADDR:  e = ERR_ADDR;
      STEP_W_REG:                 e = ERR_REG;
      STEP_W_VALUE, STEP_R_VALUE: e = ERR_VALUE;
      STEP_R_DONE:                e = ERR_STOP;
      default:                    e = ERR_OK;
    endcase
    err_of = e;
  endfunction

endpackage

// ----- rtl/i2c_master_register_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_register_sequencer
// Queues register read/write requests and steps them through an I2C master
// sequence, one bus status event at a time.
// ----------------------------------------------------------------------------
// port group  dir   handshake          payload
// in_*        in    in_valid/in_ready  i2cmrs_pkg::in_t
// out_*       out   out_valid/out_ready i2cmrs_pkg::out_t
// cfg_*       in    cfg_we             cfg_index, cfg_wdata (device address)
//
// one result beat per input beat, out_valid registered and raised the cycle after accept
// a new beat is taken every cycle while the result register is empty or drained
// out_ready low holds the result and stalls input once the register is full
// the request queue is a memory with registered read of the head entry
// synchronous active-low reset empties the queue and idles the sequencer
// ----------------------------------------------------------------------------
module i2c_master_register_sequencer #(
  parameter int DEVICE_SLOTS = 4,
  parameter int QUEUE_DEPTH  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  i2cmrs_pkg::in_t                     in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output i2cmrs_pkg::out_t                    out_data,
  input  logic                                cfg_we,
  input  logic [i2cmrs_pkg::DEV_IDX_W-1:0]    cfg_index,
  input  logic [i2cmrs_pkg::DEV_ADR_W-1:0]    cfg_wdata
);

  localparam int ADDR_SLOTS = (DEVICE_SLOTS < i2cmrs_pkg::DEV_REGS) ?
                              DEVICE_SLOTS : i2cmrs_pkg::DEV_REGS;
  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  logic [i2cmrs_pkg::DEV_ADR_W-1:0] dev_addr_r [ADDR_SLOTS];

  i2cmrs_pkg::step_t step_r, step_nxt;
  logic              active_valid_r, active_valid_nxt;
  logic              active_read_r, active_read_nxt;
  logic [1:0]        active_dev_r, active_dev_nxt;
  logic [7:0]        active_reg_r, active_reg_nxt;
  logic [7:0]        active_data_r, active_data_nxt;
  logic [2:0]        result_code_r, result_code_nxt;

  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [PTR_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  i2cmrs_pkg::entry_t queue_mem [QUEUE_DEPTH];
  i2cmrs_pkg::entry_t head_data_r;
  i2cmrs_pkg::entry_t wr_entry;
  logic               wr_en;

  logic               out_valid_r;
  i2cmrs_pkg::out_t   out_data_r;
  i2cmrs_pkg::out_t   res;

  logic               in_fire;
  logic               ev_pass;
  logic               dev_ok;
  logic [i2cmrs_pkg::DEV_ADR_W-1:0] cur_addr;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign ev_pass = i2cmrs_pkg::status_has(in_data.bus_status, i2cmrs_pkg::expect_code(step_r));
  assign dev_ok  = (int'(in_data.req_device) < DEVICE_SLOTS);

  always_comb begin
    cur_addr = '0;
    for (int i = 0; i < ADDR_SLOTS; i++) begin
      if (active_dev_r == i2cmrs_pkg::DEV_IDX_W'(i)) begin
        cur_addr = dev_addr_r[i];
      end
    end
  end

  // sequencer next step
  always_comb begin
    step_nxt = step_r;
    if (in_fire && in_data.mode == i2cmrs_pkg::MODE_EVENT) begin
      if (!ev_pass) begin
        step_nxt = i2cmrs_pkg::STEP_IDLE;
      end else begin
        unique case (step_r)
          i2cmrs_pkg::STEP_W_START: step_nxt = i2cmrs_pkg::STEP_W_ADDR;
          i2cmrs_pkg::STEP_W_ADDR:  step_nxt = i2cmrs_pkg::STEP_W_REG;
          i2cmrs_pkg::STEP_W_REG:   step_nxt = active_read_r ? i2cmrs_pkg::STEP_R_START
                                                             : i2cmrs_pkg::STEP_W_VALUE;
          i2cmrs_pkg::STEP_R_START: step_nxt = i2cmrs_pkg::STEP_R_ADDR;
          i2cmrs_pkg::STEP_R_ADDR:  step_nxt = i2cmrs_pkg::STEP_R_VALUE;
          i2cmrs_pkg::STEP_R_VALUE: step_nxt = i2cmrs_pkg::STEP_R_DONE;
          default:                  step_nxt = i2cmrs_pkg::STEP_IDLE;
        endcase
      end
    end else if (in_fire && in_data.mode == i2cmrs_pkg::MODE_POLL) begin
      if (step_r == i2cmrs_pkg::STEP_IDLE && !active_valid_r && count_r != '0) begin
        step_nxt = i2cmrs_pkg::STEP_W_START;
      end
    end
  end

  // result beat and datapath updates
  always_comb begin
    res              = '0;
    active_valid_nxt = active_valid_r;
    active_read_nxt  = active_read_r;
    active_dev_nxt   = active_dev_r;
    active_reg_nxt   = active_reg_r;
    active_data_nxt  = active_data_r;
    result_code_nxt  = result_code_r;
    head_nxt         = head_r;
    tail_nxt         = tail_r;
    count_nxt        = count_r;
    wr_en            = 1'b0;
    wr_entry.is_read  = in_data.req_is_read;
    wr_entry.device   = in_data.req_device;
    wr_entry.reg_addr = in_data.req_register;
    wr_entry.value    = in_data.req_is_read ? 8'd0 : in_data.req_value;

    if (in_fire) begin
      unique case (in_data.mode)
        i2cmrs_pkg::MODE_ENQ: begin
          if (dev_ok && count_r != CNT_FULL) begin
            wr_en        = 1'b1;
            tail_nxt     = (tail_r == PTR_LAST) ? '0 : tail_r + 1'b1;
            count_nxt    = count_r + 1'b1;
            res.accepted = 1'b1;
          end
        end
        i2cmrs_pkg::MODE_EVENT: begin
          if (step_r == i2cmrs_pkg::STEP_IDLE) begin
            res.bus_cmd = i2cmrs_pkg::CMD_NONE;
          end else if (!ev_pass) begin
            res.bus_cmd     = i2cmrs_pkg::CMD_STOP;
            result_code_nxt = i2cmrs_pkg::err_of(step_r);
          end else begin
            unique case (step_r)
              i2cmrs_pkg::STEP_W_START: begin
                res.bus_cmd  = i2cmrs_pkg::CMD_SEND;
                res.bus_byte = {cur_addr, 1'b0};
              end
              i2cmrs_pkg::STEP_W_ADDR: begin
                res.bus_cmd  = i2cmrs_pkg::CMD_SEND;
                res.bus_byte = active_reg_r;
              end
              i2cmrs_pkg::STEP_W_REG: begin
                if (active_read_r) begin
                  res.bus_cmd = i2cmrs_pkg::CMD_START;
                end else begin
                  res.bus_cmd  = i2cmrs_pkg::CMD_SEND;
                  res.bus_byte = active_data_r;
                end
              end
              i2cmrs_pkg::STEP_R_START: begin
                res.bus_cmd  = i2cmrs_pkg::CMD_SEND;
                res.bus_byte = {cur_addr, 1'b1};
              end
              i2cmrs_pkg::STEP_R_ADDR: res.bus_cmd = i2cmrs_pkg::CMD_RECV;
              i2cmrs_pkg::STEP_R_VALUE: begin
                active_data_nxt = in_data.bus_data;
                res.bus_cmd     = i2cmrs_pkg::CMD_RECV;
              end
              default: res.bus_cmd = i2cmrs_pkg::CMD_STOP;
            endcase
          end
        end
        i2cmrs_pkg::MODE_POLL: begin
          if (step_r == i2cmrs_pkg::STEP_IDLE) begin
            if (active_valid_r) begin
              res.done_res      = 1'b1;
              res.done_device   = active_dev_r;
              res.done_was_read = active_read_r;
              res.done_error    = result_code_r;
              res.read_data     = active_read_r ? active_data_r : 8'd0;
              active_valid_nxt  = 1'b0;
            end else if (count_r != '0) begin
              active_valid_nxt = 1'b1;
              active_read_nxt  = head_data_r.is_read;
              active_dev_nxt   = head_data_r.device;
              active_reg_nxt   = head_data_r.reg_addr;
              active_data_nxt  = head_data_r.value;
              result_code_nxt  = i2cmrs_pkg::ERR_OK;
              head_nxt         = (head_r == PTR_LAST) ? '0 : head_r + 1'b1;
              count_nxt        = count_r - 1'b1;
              res.bus_cmd      = i2cmrs_pkg::CMD_START;
            end
          end
        end
        default: res = '0;
      endcase
    end
  end

  // request queue, head entry read ahead with write-through on an empty queue
  always_ff @(posedge clk) begin
    if (wr_en) begin
      queue_mem[tail_r] <= wr_entry;
    end
    if (wr_en && tail_r == head_nxt) begin
      head_data_r <= wr_entry;
    end else begin
      head_data_r <= queue_mem[head_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r         <= i2cmrs_pkg::STEP_IDLE;
      active_valid_r <= 1'b0;
      head_r         <= '0;
      tail_r         <= '0;
      count_r        <= '0;
      out_valid_r    <= 1'b0;
      for (int i = 0; i < ADDR_SLOTS; i++) begin
        dev_addr_r[i] <= '0;
      end
    end else begin
      step_r         <= step_nxt;
      active_valid_r <= active_valid_nxt;
      head_r         <= head_nxt;
      tail_r         <= tail_nxt;
      count_r        <= count_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      for (int i = 0; i < ADDR_SLOTS; i++) begin
        if (cfg_we && cfg_index == i2cmrs_pkg::DEV_IDX_W'(i)) begin
          dev_addr_r[i] <= cfg_wdata;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    active_read_r <= active_read_nxt;
    active_dev_r  <= active_dev_nxt;
    active_reg_r  <= active_reg_nxt;
    active_data_r <= active_data_nxt;
    result_code_r <= result_code_nxt;
    if (in_fire) begin
      out_data_r <= res;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("queue count beyond depth");

  a_busy_has_req: assert property (@(posedge clk) disable iff (!rst_n)
    step_r != i2cmrs_pkg::STEP_IDLE |-> active_valid_r)
    else $error("sequence running without an active request");

  a_beat_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted beat produced no result");

  a_done_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.done_res |-> out_data_r.bus_cmd == i2cmrs_pkg::CMD_NONE)
    else $error("report beat carries a bus command");

  a_start_pops: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.mode == i2cmrs_pkg::MODE_POLL && step_r == i2cmrs_pkg::STEP_IDLE
    && step_nxt == i2cmrs_pkg::STEP_W_START
    |=> count_r == $past(count_r) - 1'b1)
    else $error("started request not taken from queue");

endmodule

// ----- tb/i2c_master_register_sequencer_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_register_sequencer_test
// Self-checking testbench. A queue-fed driver sends request, bus event and
// poll beats. A beat-level predictor of the sequencer, with its own request
// queue and device table, works out one response per accepted beat. The
// monitor compares every response beat field by field. Device addresses are
// reprogrammed between phases, and both sides idle at random.
// ----------------------------------------------------------------------------
module i2c_master_register_sequencer_test;

  localparam int REQ_DEPTH = 16;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_NONE  = 2'd2
  } req_kind_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  i2cmrs_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  i2cmrs_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [i2cmrs_pkg::DEV_IDX_W-1:0] cfg_index = '0;
  logic [i2cmrs_pkg::DEV_ADR_W-1:0] cfg_wdata = '0;

  i2c_master_register_sequencer i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // predictor state
  logic [6:0]         dev_addr [4] = '{default: '0};
  i2cmrs_pkg::step_t  seq_step = i2cmrs_pkg::STEP_IDLE;
  req_kind_t          act_kind = KIND_NONE;
  logic [1:0]         act_dev = '0;
  logic [7:0]         act_reg = '0;
  logic [7:0]         act_data = '0;
  logic [2:0]         result_code = i2cmrs_pkg::ERR_OK;
  i2cmrs_pkg::entry_t req_q [$];

  i2cmrs_pkg::in_t  in_beats [$];
  i2cmrs_pkg::out_t response_q [$];
  i2cmrs_pkg::out_t got_want;
  bit   plan_kinds [$];
  int   items_queued = 0;
  int   items_taken = 0;
  int   useful_beats = 0;
  int   fail_count = 0;
  int   in_idle_pct = 0;
  int   out_idle_pct = 0;
  int   in_gap = 0;
  int   ready_gap = 0;
  logic in_taken = 1'b0;

  function automatic logic status_carries(input logic [7:0] st, input logic [7:0] code);
    return (st & i2cmrs_pkg::ST_CODE_BITS & code) == code;
  endfunction

  function automatic i2cmrs_pkg::out_t response_for(input i2cmrs_pkg::in_t b);
    i2cmrs_pkg::out_t r;
    i2cmrs_pkg::entry_t e;
    logic [2:0] fail_err;
    r = '0;
    fail_err = i2cmrs_pkg::ERR_OK;
    case (b.mode)
      i2cmrs_pkg::MODE_ENQ: begin
        // every 2-bit slot exists, only a full queue refuses
        if (req_q.size() < REQ_DEPTH) begin
          e.is_read = b.req_is_read;
          e.device = b.req_device;
          e.reg_addr = b.req_register;
          e.value = b.req_is_read ? 8'h00 : b.req_value;
          req_q.push_back(e);
          r.accepted = 1'b1;
        end
      end
      i2cmrs_pkg::MODE_EVENT: begin
        case (seq_step)
          i2cmrs_pkg::STEP_W_START:
            if (status_carries(b.bus_status, i2cmrs_pkg::ST_START)) begin
              r.bus_cmd = i2cmrs_pkg::CMD_SEND;
              r.bus_byte = {dev_addr[act_dev], 1'b0};
              seq_step = i2cmrs_pkg::STEP_W_ADDR;
            end else fail_err = i2cmrs_pkg::ERR_START;
          i2cmrs_pkg::STEP_W_ADDR:
            if (status_carries(b.bus_status, i2cmrs_pkg::ST_MT_SLA_ACK)) begin
              r.bus_cmd = i2cmrs_pkg::CMD_SEND;
              r.bus_byte = act_reg;
              seq_step = i2cmrs_pkg::STEP_W_REG;
            end else fail_err = i2cmrs_pkg::ERR_ADDR;
          i2cmrs_pkg::STEP_W_REG:
            if (status_carries(b.bus_status, i2cmrs_pkg::ST_MT_DATA_ACK)) begin
              if (act_kind == KIND_WRITE) begin
                r.bus_cmd = i2cmrs_pkg::CMD_SEND;
                r.bus_byte = act_data;
                seq_step = i2cmrs_pkg::STEP_W_VALUE;
              end else begin
                r.bus_cmd = i2cmrs_pkg::CMD_START;
                seq_step = i2cmrs_pkg::STEP_R_START;
              end
            end else fail_err = i2cmrs_pkg::ERR_REG;
          i2cmrs_pkg::STEP_W_VALUE:
            if (status_carries(b.bus_status, i2cmrs_pkg::ST_MT_DATA_ACK)) begin
              r.bus_cmd = i2cmrs_pkg::CMD_STOP;
              seq_step = i2cmrs_pkg::STEP_IDLE;
            end else fail_err = i2cmrs_pkg::ERR_VALUE;
          i2cmrs_pkg::STEP_R_START:
            if (status_carries(b.bus_status, i2cmrs_pkg::ST_REP_START)) begin
              r.bus_cmd = i2cmrs_pkg::CMD_SEND;
              r.bus_byte = {dev_addr[act_dev], 1'b1};
              seq_step = i2cmrs_pkg::STEP_R_ADDR;
            end else fail_err = i2cmrs_pkg::ERR_START;
          i2cmrs_pkg::STEP_R_ADDR:
            if (status_carries(b.bus_status, i2cmrs_pkg::ST_MR_SLA_ACK)) begin
              r.bus_cmd = i2cmrs_pkg::CMD_RECV;
              seq_step = i2cmrs_pkg::STEP_R_VALUE;
            end else fail_err = i2cmrs_pkg::ERR_ADDR;
          i2cmrs_pkg::STEP_R_VALUE:
            if (status_carries(b.bus_status, i2cmrs_pkg::ST_MR_DATA_ACK)) begin
              act_data = b.bus_data;
              r.bus_cmd = i2cmrs_pkg::CMD_RECV;
              seq_step = i2cmrs_pkg::STEP_R_DONE;
            end else fail_err = i2cmrs_pkg::ERR_VALUE;
          i2cmrs_pkg::STEP_R_DONE:
            if (status_carries(b.bus_status, i2cmrs_pkg::ST_MR_DATA_NACK)) begin
              r.bus_cmd = i2cmrs_pkg::CMD_STOP;
              seq_step = i2cmrs_pkg::STEP_IDLE;
            end else fail_err = i2cmrs_pkg::ERR_STOP;
          default: seq_step = i2cmrs_pkg::STEP_IDLE;
        endcase
        // a missing nack at the end stops the same way as any failed check
        if (fail_err != i2cmrs_pkg::ERR_OK) begin
          result_code = fail_err;
          r.bus_cmd = i2cmrs_pkg::CMD_STOP;
          seq_step = i2cmrs_pkg::STEP_IDLE;
        end
      end
      i2cmrs_pkg::MODE_POLL: begin
        if (seq_step == i2cmrs_pkg::STEP_IDLE) begin
          if (act_kind != KIND_NONE) begin
            r.done_res = 1'b1;
            r.done_device = act_dev;
            r.done_was_read = (act_kind == KIND_READ);
            r.done_error = result_code;
            r.read_data = (act_kind == KIND_READ) ? act_data : 8'h00;
            act_kind = KIND_NONE;
            act_dev = '0;
            act_reg = '0;
            act_data = '0;
            result_code = i2cmrs_pkg::ERR_OK;
          end else if (req_q.size() > 0) begin
            e = req_q.pop_front();
            act_kind = e.is_read ? KIND_READ : KIND_WRITE;
            act_dev = e.device;
            act_reg = e.reg_addr;
            act_data = e.value;
            result_code = i2cmrs_pkg::ERR_OK;
            seq_step = i2cmrs_pkg::STEP_W_START;
            r.bus_cmd = i2cmrs_pkg::CMD_START;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int pick_gap(input int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 10);
    return $urandom_range(3, 1);
  endfunction

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  // input driver: holds a beat until it is taken, then idles or loads the next
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (in_beats.size() > 0) begin
        in_data <= in_beats.pop_front();
        in_valid <= 1'b1;
        in_gap = pick_gap(in_idle_pct);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (ready_gap > 0) begin
      ready_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      ready_gap = pick_gap(out_idle_pct);
    end
  end

  // monitor: checks response beats, then predicts for the beat taken now
  always @(posedge clk) begin
    in_taken <= in_valid && in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (response_q.size() == 0) begin
          $error("response beat with no request beat pending");
          fail_count++;
        end else begin
          got_want = response_q.pop_front();
          check_field("accepted", 8'(got_want.accepted), 8'(out_data.accepted));
          check_field("bus_cmd", 8'(got_want.bus_cmd), 8'(out_data.bus_cmd));
          check_field("bus_byte", got_want.bus_byte, out_data.bus_byte);
          check_field("done_res", 8'(got_want.done_res), 8'(out_data.done_res));
          check_field("done_device", 8'(got_want.done_device), 8'(out_data.done_device));
          check_field("done_was_read", 8'(got_want.done_was_read),
                      8'(out_data.done_was_read));
          check_field("done_error", 8'(got_want.done_error), 8'(out_data.done_error));
          check_field("read_data", got_want.read_data, out_data.read_data);
        end
      end
      if (in_valid && in_ready) begin
        response_q.push_back(response_for(in_data));
        items_taken++;
      end
    end
  end

  function automatic i2cmrs_pkg::in_t rand_beat(input logic [1:0] m);
    i2cmrs_pkg::in_t b;
    b.mode = m;
    b.req_is_read = 1'($urandom_range(1));
    b.req_device = 2'($urandom_range(3));
    b.req_register = 8'($urandom_range(255));
    b.req_value = 8'($urandom_range(255));
    b.bus_status = 8'($urandom_range(255));
    b.bus_data = 8'($urandom_range(255));
    return b;
  endfunction

  function automatic logic [7:0] good_status(input logic [7:0] code);
    if ($urandom_range(1) == 0) return code;
    return code | 8'($urandom_range(255));
  endfunction

  // clear one of the bits the step waits for
  function automatic logic [7:0] failing_status(input logic [7:0] code);
    int k;
    logic [7:0] st;
    st = 8'($urandom_range(255));
    do k = $urandom_range(7, 3); while (!code[k]);
    st[k] = 1'b0;
    return st;
  endfunction

  task automatic send(input i2cmrs_pkg::in_t b, input bit counts);
    in_beats.push_back(b);
    items_queued++;
    if (counts) useful_beats++;
  endtask

  task automatic send_poll(input bit counts);
    send(rand_beat(i2cmrs_pkg::MODE_POLL), counts);
  endtask

  task automatic send_event(input logic [7:0] st, input logic [7:0] data);
    i2cmrs_pkg::in_t b;
    b = rand_beat(i2cmrs_pkg::MODE_EVENT);
    b.bus_status = st;
    b.bus_data = data;
    send(b, 1'b1);
  endtask

  task automatic send_enq(input logic rd, input logic [1:0] dev,
                          input logic [7:0] reg_addr, input logic [7:0] val);
    i2cmrs_pkg::in_t b;
    b = rand_beat(i2cmrs_pkg::MODE_ENQ);
    b.req_is_read = rd;
    b.req_device = dev;
    b.req_register = reg_addr;
    b.req_value = val;
    send(b, 1'b1);
  endtask

  // start poll, the event beats of one request, then the report poll
  task automatic run_transaction(input bit is_read, input int abort_pct);
    logic [7:0] codes [7];
    int n;
    bit aborted;
    if (is_read) begin
      codes = '{i2cmrs_pkg::ST_START, i2cmrs_pkg::ST_MT_SLA_ACK,
                i2cmrs_pkg::ST_MT_DATA_ACK, i2cmrs_pkg::ST_REP_START,
                i2cmrs_pkg::ST_MR_SLA_ACK, i2cmrs_pkg::ST_MR_DATA_ACK,
                i2cmrs_pkg::ST_MR_DATA_NACK};
      n = 7;
    end else begin
      codes = '{i2cmrs_pkg::ST_START, i2cmrs_pkg::ST_MT_SLA_ACK,
                i2cmrs_pkg::ST_MT_DATA_ACK, i2cmrs_pkg::ST_MT_DATA_ACK,
                8'h00, 8'h00, 8'h00};
      n = 4;
    end
    aborted = 1'b0;
    send_poll(1'b1);
    for (int i = 0; i < n && !aborted; i++) begin
      if ($urandom_range(99) < 5) send_poll(1'b0);
      if ($urandom_range(99) < 3)
        send_event(8'($urandom_range(255)), 8'($urandom_range(255)));
      if ($urandom_range(99) < abort_pct) begin
        send_event(failing_status(codes[i]), 8'($urandom_range(255)));
        aborted = 1'b1;
      end else begin
        send_event(good_status(codes[i]), 8'($urandom_range(255)));
      end
    end
    send_poll(1'b1);
  endtask

  task automatic write_device(input int idx, input logic [6:0] addr);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= 2'(idx);
    cfg_wdata <= addr;
    dev_addr[idx] = addr;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic directed_beats();
    i2cmrs_pkg::in_t b;
    send_poll(1'b1);
    send_event(8'hFF, 8'hFF);
    b = '1;
    b.mode = MODE_UNUSED;
    send(b, 1'b1);
    send_enq(1'b0, 2'd3, 8'hFF, 8'hFF);
    send_enq(1'b1, 2'd1, 8'h00, 8'hFF);
    send_enq(1'b0, 2'd0, 8'h00, 8'h00);
    // write to slot 3, with a poll while busy
    send_poll(1'b1);
    send_poll(1'b1);
    send_event(i2cmrs_pkg::ST_START, 8'h00);
    send_event(i2cmrs_pkg::ST_MT_SLA_ACK, 8'h00);
    send_event(i2cmrs_pkg::ST_MT_DATA_ACK, 8'h00);
    send_event(i2cmrs_pkg::ST_MT_DATA_ACK, 8'h00);
    send_poll(1'b1);
    // read from slot 1, all-ones status passes every check
    send_poll(1'b1);
    send_event(i2cmrs_pkg::ST_START, 8'h00);
    send_event(8'hFF, 8'h00);
    send_event(i2cmrs_pkg::ST_MT_DATA_ACK, 8'h00);
    send_event(i2cmrs_pkg::ST_REP_START, 8'h00);
    send_event(i2cmrs_pkg::ST_MR_SLA_ACK, 8'h00);
    send_event(i2cmrs_pkg::ST_MR_DATA_ACK, 8'hFF);
    send_event(8'hFF, 8'h00);
    send_poll(1'b1);
    // write to slot 0 that fails on start
    send_poll(1'b1);
    send_event(8'h00, 8'h00);
    send_poll(1'b1);
  endtask

  task automatic random_beats(input int budget);
    int stop_at;
    int pick;
    int n;
    i2cmrs_pkg::in_t b;
    stop_at = useful_beats + budget;
    while (useful_beats < stop_at) begin
      pick = $urandom_range(99);
      if (plan_kinds.size() == 0 || pick < 30) begin
        // now and then overfill the request queue
        n = ($urandom_range(19) == 0) ? REQ_DEPTH + 2 : $urandom_range(3, 1);
        repeat (n) begin
          b = rand_beat(i2cmrs_pkg::MODE_ENQ);
          send(b, 1'b1);
          if (plan_kinds.size() < REQ_DEPTH) plan_kinds.push_back(b.req_is_read);
        end
      end else if (pick < 38) begin
        send(rand_beat($urandom_range(1) ? i2cmrs_pkg::MODE_EVENT : MODE_UNUSED), 1'b0);
      end else begin
        run_transaction(plan_kinds.pop_front(), 8);
      end
    end
  endtask

  task automatic wait_drained();
    while (items_taken != items_queued || response_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    logic [6:0] addrs [4];
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: addrs = '{7'd0, 7'd127, 7'h55, 7'h2A};
        1: addrs = '{default: 7'd0};
        2: addrs = '{default: 7'd127};
        default:
          foreach (addrs[i]) addrs[i] = 7'($urandom_range(127));
      endcase
      foreach (addrs[i]) write_device(i, addrs[i]);
      case (ph)
        1: begin in_idle_pct = 25; out_idle_pct = 25; end
        2: begin in_idle_pct = 0;  out_idle_pct = 50; end
        3: begin in_idle_pct = 50; out_idle_pct = 0;  end
        5: begin in_idle_pct = 70; out_idle_pct = 70; end
        default: begin in_idle_pct = 0; out_idle_pct = 0; end
      endcase
      if (ph == 0) directed_beats();
      else random_beats(80);
      wait_drained();
    end
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("i2c_master_register_sequencer_test OK");
    end else begin
      $display("i2c_master_register_sequencer_test NOT OK");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("i2c_master_register_sequencer_test NOT OK");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/i2cmrs_pkg.sv
rtl/i2c_master_register_sequencer.sv
tb/i2c_master_register_sequencer_test.sv
